@@ src/ddra_pkg.sv @@
// package for the deadlock detecting resource allocator
// holds sizes, payload structs, status codes and sequencer states; no dependencies
`default_nettype none
package ddra_pkg;
  localparam int NUM_PROCS = 8;
  localparam int NUM_RES = 4;
  localparam int UNIT_BITS = 8;
  localparam int PW = $clog2(NUM_PROCS);
  localparam int RW = $clog2(NUM_RES);
  localparam logic [UNIT_BITS-1:0] UNIT_MAX = {UNIT_BITS{1'b1}};

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_TOTAL0 = 3'd1;
  localparam logic [2:0] REG_TOTAL3 = 3'd4;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_WAIT = 2'd1,
    ST_INVALID = 2'd2,
    ST_OVER_RELEASE = 2'd3
  } status_t;

  typedef struct packed {
    logic cmd;
    logic [2:0] proc_slot;
    logic [1:0] res_slot;
    logic [7:0] unit_count;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic deadlock_found;
    logic [7:0] deadlocked_mask;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_ADJ,
    S_CLOSE,
    S_CHECK,
    S_OUT
  } seq_state_t;
endpackage
`default_nettype wire

@@ src/ddra_closure.sv @@
// iterative transitive closure and cycle check over the wait-for matrix
// depends on ddra_pkg
`default_nettype none
module ddra_closure
  import ddra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [NUM_PROCS-1:0][NUM_PROCS-1:0] adj,
  output logic done,
  output logic cycle
);
  logic [NUM_PROCS-1:0][NUM_PROCS-1:0] reach_r, reach_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic [PW:0] pass_r, pass_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [NUM_PROCS-1:0] row_acc;

  // one row per cycle: or in the reach row of every reached node
  always_comb begin
    row_acc = reach_r[row_r];
    for (int q = 0; q < NUM_PROCS; q++) begin
      if (reach_r[row_r][q]) row_acc = row_acc | reach_r[q];
    end
  end

  always_comb begin
    reach_nxt = reach_r;
    row_nxt = row_r;
    pass_nxt = pass_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      reach_nxt = adj;
      row_nxt = '0;
      pass_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      reach_nxt[row_r] = row_acc;
      row_nxt = row_r + 1'b1;
      if (row_r == PW'(NUM_PROCS - 1)) begin
        row_nxt = '0;
        pass_nxt = pass_r + 1'b1;
        if (pass_r == (PW+1)'(PW)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    reach_r <= reach_nxt;
    row_r <= row_nxt;
    pass_r <= pass_nxt;
  end

  always_comb begin
    cycle = 1'b0;
    for (int p = 0; p < NUM_PROCS; p++) cycle = cycle | reach_r[p][p];
  end
  assign done = done_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("start lost");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without work");
endmodule
`default_nettype wire

@@ src/deadlock_detecting_resource_allocator_unit.sv @@
// top level of the deadlock detecting resource allocator
// depends on ddra_pkg and ddra_closure
`default_nettype none
// usage:
//   in_ channel carries one event beat (request or release of units of one
//   resource by one process slot). out_ channel returns one beat per event:
//   status, deadlock flag and the mask of waiting holders.
//   cfg_ is an apb-style port: reg 0 enables process slots, regs 1..4 set
//   the total units of each resource and reload its free count.
// timing:
//   an event is applied in the update state, then the wait-for matrix is built
//   one process row per cycle, then the closure unit squares the reach
//   relation one row per cycle for 4 passes; the diagonal is then checked
//   and the result lands in the output register.
//   in_ready is low from acceptance until the result beat has been taken,
//   so one event is in flight at a time.
// reset:
//   held counts and table valid flags clear, totals and free units load 1, enable mask clears.
// stall:
//   the result beat holds in the output register while out_ready is low;
//   no new event is taken until it leaves.
module deadlock_detecting_resource_allocator_unit
  import ddra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire in_beat_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output out_beat_t out_data,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  // per-entry tables, flattened as proc*NUM_RES+res
  localparam int NE = NUM_PROCS * NUM_RES;
  logic [NE-1:0][UNIT_BITS-1:0] held_r;
  logic [NE-1:0] present_r, maxv_r, needv_r;
  logic [NE-1:0][UNIT_BITS:0] maxc_r;
  logic [NE-1:0][UNIT_BITS+1:0] need_r;
  logic [NUM_RES-1:0][UNIT_BITS-1:0] free_r, total_r;
  logic [NUM_PROCS-1:0] en_r;

  seq_state_t state_r, state_nxt;
  in_beat_t ev_r;
  logic [1:0] status_r;
  logic [PW-1:0] row_r;
  logic [NUM_PROCS-1:0][NUM_PROCS-1:0] adj_r;
  logic out_valid_r;
  out_beat_t out_r;
  logic cl_start, cl_done, cl_cycle;

  // apb
  logic [2:0] reg_idx;
  logic cfg_wr;
  assign reg_idx = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ENABLE) prdata = 32'(en_r);
    else if (reg_idx >= REG_TOTAL0 && reg_idx <= REG_TOTAL3)
      prdata = 32'(total_r[RW'(reg_idx - REG_TOTAL0)]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_ADJ;
      S_ADJ:    if (row_r == PW'(NUM_PROCS - 1)) state_nxt = S_CLOSE;
      S_CLOSE:  if (cl_done) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state_r == S_IDLE);
    cl_start = (state_r == S_ADJ) && (row_r == PW'(NUM_PROCS - 1));
  end
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // event datapath
  logic [$clog2(NE)-1:0] ei;
  logic [UNIT_BITS-1:0] u, h, fr;
  logic [UNIT_BITS:0] want, cur, newmax, fsum;
  logic [UNIT_BITS-1:0] held_sat, free_sat;
  assign ei = {ev_r.proc_slot, ev_r.res_slot};
  assign u = ev_r.unit_count;
  assign h = present_r[ei] ? held_r[ei] : '0;
  assign fr = free_r[ev_r.res_slot];
  assign want = {1'b0, h} + {1'b0, u};
  assign cur = maxv_r[ei] ? maxc_r[ei] : '0;
  assign newmax = (cur > want) ? cur : want;
  // saturated held after a grant and free after a release
  assign held_sat = (want > {1'b0, UNIT_MAX}) ? UNIT_MAX : want[UNIT_BITS-1:0];
  assign fsum = {1'b0, fr} + {1'b0, u};
  assign free_sat = (fsum > {1'b0, UNIT_MAX}) ? UNIT_MAX : fsum[UNIT_BITS-1:0];

  // adjacency row builder for process row_r
  logic [NUM_PROCS-1:0] adj_row;
  always_comb begin
    adj_row = '0;
    for (int r = 0; r < NUM_RES; r++) begin
      logic signed [UNIT_BITS+1:0] nd;
      nd = needv_r[{row_r, RW'(r)}] ? need_r[{row_r, RW'(r)}] : '0;
      if (en_r[row_r] && present_r[{row_r, RW'(r)}] &&
          nd > $signed({2'b00, free_r[r]})) begin
        for (int q = 0; q < NUM_PROCS; q++) begin
          if (PW'(q) != row_r && en_r[q] && present_r[{PW'(q), RW'(r)}] &&
              held_r[{PW'(q), RW'(r)}] != '0)
            adj_row[q] = 1'b1;
        end
      end
    end
  end

  logic [NUM_PROCS-1:0] wmask;
  always_comb begin
    wmask = '0;
    for (int e = 0; e < NE; e++) begin
      if (en_r[e / NUM_RES] && present_r[e] && needv_r[e] &&
          $signed(need_r[e]) > 0)
        wmask[e / NUM_RES] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      en_r <= '0;
      present_r <= '0;
      maxv_r <= '0;
      needv_r <= '0;
      held_r <= '0;
      for (int r = 0; r < NUM_RES; r++) begin
        total_r[r] <= UNIT_BITS'(1);
        free_r[r] <= UNIT_BITS'(1);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (reg_idx == REG_ENABLE) en_r <= pwdata[NUM_PROCS-1:0];
        else if (reg_idx >= REG_TOTAL0 && reg_idx <= REG_TOTAL3) begin
          total_r[RW'(reg_idx - REG_TOTAL0)] <= pwdata[UNIT_BITS-1:0];
          free_r[RW'(reg_idx - REG_TOTAL0)] <= pwdata[UNIT_BITS-1:0];
        end
      end
      if (state_r == S_IDLE && in_valid) ev_r <= in_data;
      if (state_r == S_UPDATE) begin
        row_r <= '0;
        if (!en_r[ev_r.proc_slot]) begin
          status_r <= ST_INVALID;
        end else begin
          present_r[ei] <= 1'b1;
          if (ev_r.cmd == CMD_REQUEST) begin
            needv_r[ei] <= 1'b1;
            maxv_r[ei] <= 1'b1;
            if (u > fr) begin
              maxc_r[ei] <= newmax;
              need_r[ei] <= (UNIT_BITS+2)'(newmax) - (UNIT_BITS+2)'(h);
              held_r[ei] <= h;
              status_r <= ST_WAIT;
            end else begin
              held_r[ei] <= held_sat;
              free_r[ev_r.res_slot] <= fr - u;
              if (!maxv_r[ei]) begin
                maxc_r[ei] <= (UNIT_BITS+1)'(u);
                need_r[ei] <= (UNIT_BITS+2)'(u) - (UNIT_BITS+2)'(held_sat);
              end else begin
                need_r[ei] <= (UNIT_BITS+2)'(maxc_r[ei]) - (UNIT_BITS+2)'(held_sat);
              end
              status_r <= ST_DONE;
            end
          end else begin
            if (h < u) begin
              held_r[ei] <= h;
              status_r <= ST_OVER_RELEASE;
            end else begin
              held_r[ei] <= h - u;
              free_r[ev_r.res_slot] <= free_sat;
              status_r <= ST_DONE;
            end
          end
        end
      end
      if (state_r == S_ADJ) begin
        adj_r[row_r] <= adj_row;
        row_r <= row_r + 1'b1;
      end
      if (state_r == S_CHECK) begin
        out_valid_r <= 1'b1;
        out_r.status <= status_r;
        out_r.deadlock_found <= cl_cycle;
        out_r.deadlocked_mask <= cl_cycle ? wmask : '0;
      end
      if (state_r == S_OUT && out_ready) out_valid_r <= 1'b0;
    end
  end

  // adj_r row NUM_PROCS-1 is written on the start edge; closure loads the adj_full view
  logic [NUM_PROCS-1:0][NUM_PROCS-1:0] adj_full;
  always_comb begin
    adj_full = adj_r;
    adj_full[NUM_PROCS-1] = adj_row;
  end

  ddra_closure u_closure (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cl_start),
    .adj   (cl_start ? adj_full : adj_r),
    .done  (cl_done),
    .cycle (cl_cycle)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("input open with result pending");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result outside output state");
  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.deadlock_found) |-> out_r.deadlocked_mask == '0)
    else $error("mask without deadlock");
endmodule
`default_nettype wire

@@ tb/sv/tb_deadlock_detecting_resource_allocator_unit.sv @@
// testbench for the deadlock detecting resource allocator unit
// predicts status, deadlock flag and holder mask per event beat; depends on ddra_pkg
module tb_deadlock_detecting_resource_allocator_unit
  import ddra_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // allocator state mirror plus expected result queue
  class alloc_scoreboard;
    bit [7:0] enable_mask;
    bit [7:0] held[8][4];
    bit present[8][4];
    bit [8:0] max_claim[8][4];
    bit max_ok[8][4];
    int need[8][4];
    bit need_ok[8][4];
    bit [7:0] free_cnt[4];
    out_beat_t pending[$];
    int mismatches;
    int checked;
    int deadlocks;
    int waits;

    function void clear();
      enable_mask = 0;
      for (int p = 0; p < 8; p++)
        for (int r = 0; r < 4; r++) begin
          held[p][r] = 0; present[p][r] = 0; max_claim[p][r] = 0;
          max_ok[p][r] = 0; need[p][r] = 0; need_ok[p][r] = 0;
        end
      for (int r = 0; r < 4; r++) free_cnt[r] = 1;
    endfunction

    function void write_reg(int idx, bit [7:0] v);
      if (idx == REG_ENABLE) enable_mask = v;
      else free_cnt[idx - REG_TOTAL0] = v;
    endfunction

    function bit cycle_exists();
      bit [7:0] adj[8];
      bit [7:0] reach[8];
      int nd;
      for (int p = 0; p < 8; p++) begin
        adj[p] = 0;
        if (!enable_mask[p]) continue;
        for (int r = 0; r < 4; r++) begin
          if (!present[p][r]) continue;
          nd = need_ok[p][r] ? need[p][r] : 0;
          if (nd <= int'(free_cnt[r])) continue;
          for (int q = 0; q < 8; q++)
            if (q != p && enable_mask[q] && present[q][r] && held[q][r] > 0)
              adj[p][q] = 1;
        end
      end
      reach = adj;
      for (int k = 0; k < 8; k++)
        for (int p = 0; p < 8; p++)
          for (int q = 0; q < 8; q++)
            if (reach[p][q]) reach[p] |= adj[q];
      for (int p = 0; p < 8; p++)
        if (reach[p][p]) return 1;
      return 0;
    endfunction

    function void note_event(in_beat_t b);
      out_beat_t e;
      int p, r, u, want, cur, s;
      p = b.proc_slot; r = b.res_slot; u = b.unit_count;
      if (!enable_mask[p]) e.status = ST_INVALID;
      else begin
        if (!present[p][r]) begin
          present[p][r] = 1; held[p][r] = 0;
        end
        if (b.cmd == CMD_REQUEST) begin
          if (u > free_cnt[r]) begin
            want = held[p][r] + u;
            cur = max_ok[p][r] ? max_claim[p][r] : 0;
            max_claim[p][r] = 9'(cur > want ? cur : want);
            max_ok[p][r] = 1;
            need[p][r] = int'(max_claim[p][r]) - int'(held[p][r]);
            need_ok[p][r] = 1;
            e.status = ST_WAIT;
          end else begin
            s = held[p][r] + u;
            held[p][r] = 8'(s > 255 ? 255 : s);
            free_cnt[r] -= 8'(u);
            if (!max_ok[p][r]) begin
              max_claim[p][r] = 9'(u); max_ok[p][r] = 1;
            end
            need[p][r] = int'(max_claim[p][r]) - int'(held[p][r]);
            need_ok[p][r] = 1;
            e.status = ST_DONE;
          end
        end else if (held[p][r] < u) e.status = ST_OVER_RELEASE;
        else begin
          held[p][r] -= 8'(u);
          s = free_cnt[r] + u;
          free_cnt[r] = 8'(s > 255 ? 255 : s);
          e.status = ST_DONE;
        end
      end
      e.deadlock_found = cycle_exists();
      e.deadlocked_mask = 0;
      if (e.deadlock_found)
        for (int q = 0; q < 8; q++)
          if (enable_mask[q])
            for (int k = 0; k < 4; k++)
              if (present[q][k] && need_ok[q][k] && need[q][k] > 0) e.deadlocked_mask[q] = 1;
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", a);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.deadlock_found) deadlocks++;
      if (a.status == ST_WAIT) waits++;
      if (a.status !== e.status || a.deadlock_found !== e.deadlock_found ||
          a.deadlocked_mask !== e.deadlocked_mask) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, deadlock exp %0b got %0b, mask exp %h got %h",
                   e.status, a.status, e.deadlock_found, a.deadlock_found,
                   e.deadlocked_mask, a.deadlocked_mask);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_beat_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  alloc_scoreboard sb;
  bit sink_idle_ok = 1;   // random stalls on the result side
  bit hold_off = 0;       // long receiver stall for backpressure
  int idle_cycles = 0;
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  deadlock_detecting_resource_allocator_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // result side: random stall bursts, checks every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 0;
      else if (burst > 0) begin
        burst--; out_ready <= 0;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1; out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // apb write: setup then access cycle; the caller drops psel after the last one
  task automatic cfg_write(int idx, bit [7:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // wait until all expected beats arrived, then settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // valid stays up after acceptance only when the next beat follows at once
  task automatic send_event(bit c, int p, int r, int u, bit gaps);
    in_beat_t b;
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    b.cmd = c; b.proc_slot = 3'(p); b.res_slot = 2'(r); b.unit_count = 8'(u);
    in_valid <= 1; in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(b);
    sent++;
  endtask

  task automatic configure(bit [7:0] en, bit [7:0] t0, bit [7:0] t1, bit [7:0] t2,
                           bit [7:0] t3);
    in_valid <= 0;
    drain();
    cfg_write(REG_ENABLE, en);
    cfg_write(REG_TOTAL0, t0);
    cfg_write(REG_TOTAL0 + 1, t1);
    cfg_write(REG_TOTAL0 + 2, t2);
    cfg_write(REG_TOTAL3, t3);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // mostly small unit counts so grants and waits mix, some extremes
  function automatic int pick_units(int limit);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(0, limit);
    endcase
  endfunction

  initial begin
    bit c;
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: disabled slot, grants, over-release, classic two-process deadlock
    send_event(CMD_REQUEST, 0, 0, 1, 0);
    configure(8'h03, 8'd1, 8'd1, 8'd1, 8'd255);
    send_event(CMD_REQUEST, 0, 0, 1, 0);
    send_event(CMD_REQUEST, 1, 1, 1, 0);
    send_event(CMD_REQUEST, 0, 1, 1, 0);
    send_event(CMD_REQUEST, 1, 0, 1, 0);
    send_event(CMD_RELEASE, 0, 0, 5, 0);
    send_event(CMD_RELEASE, 1, 1, 1, 0);
    send_event(CMD_REQUEST, 7, 2, 3, 0);
    send_event(CMD_REQUEST, 0, 3, 255, 0);
    send_event(CMD_REQUEST, 0, 3, 0, 0);
    send_event(CMD_RELEASE, 0, 3, 255, 0);
    send_event(CMD_RELEASE, 0, 3, 255, 0);
    send_event(CMD_RELEASE, 1, 2, 0, 0);
    send_event(CMD_REQUEST, 1, 2, 2, 0);
    configure(8'hff, 8'd255, 8'd1, 8'd255, 8'd1);
    send_event(CMD_REQUEST, 6, 0, 255, 0);
    send_event(CMD_RELEASE, 6, 0, 255, 0);
    send_event(CMD_REQUEST, 5, 1, 1, 0);
    send_event(CMD_REQUEST, 4, 1, 1, 0);
    configure(8'hf0, 8'd3, 8'd3, 8'd3, 8'd3);

    // backpressure: receiver holds off long while sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        repeat (4) send_event(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                              $urandom_range(0, 3), $urandom_range(0, 3), 0);
      end
    join

    // random phases with varying enable masks and totals
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) sink_idle_ok = 0;
      if (ph == 0) configure(8'hff, 8'd2, 8'd2, 8'd2, 8'd2);
      else if (ph == 5) configure(8'h00, 8'd255, 8'd255, 8'd255, 8'd255);
      else configure(8'($urandom_range(0, 255)) | 8'h0f, 8'($urandom_range(1, 6)),
                     8'($urandom_range(1, 6)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 4)));
      for (int i = 0; i < 100; i++) begin
        c = $urandom_range(0, 2) == 0;
        send_event(c, $urandom_range(0, 7), $urandom_range(0, 3), pick_units(4), ph != 13);
      end
    end

    in_valid <= 0;
    drain();
    $display("covered %0d events: %0d waits, %0d deadlock reports, several configurations",
             sb.checked, sb.waits, sb.deadlocks);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
